[rtl/core/est_pkg.sv]
// Shared types, sizes and codes for the entity signature table.
// Used by every module under rtl/core; depends on nothing.
package est_pkg;

   localparam int MAX_ENTITIES   = 64;
   localparam int NUM_COMPONENTS = 32;

   localparam int EntW   = $clog2(MAX_ENTITIES);
   localparam int CntW   = $clog2(MAX_ENTITIES + 1);
   localparam int CmdW   = 3;
   localparam int CompW  = 5;
   localparam int QueryW = 32;
   localparam int StatW  = 3;
   localparam int SigW   = NUM_COMPONENTS;

   localparam logic [CmdW-1:0] CMD_CREATE  = 3'd0;
   localparam logic [CmdW-1:0] CMD_DESTROY = 3'd1;
   localparam logic [CmdW-1:0] CMD_SET     = 3'd2;
   localparam logic [CmdW-1:0] CMD_CLEAR   = 3'd3;
   localparam logic [CmdW-1:0] CMD_VIEW    = 3'd4;

   localparam logic [StatW-1:0] ST_OK         = 3'd0;
   localparam logic [StatW-1:0] ST_FULL       = 3'd1;
   localparam logic [StatW-1:0] ST_BAD_HANDLE = 3'd2;
   localparam logic [StatW-1:0] ST_BAD_COMP   = 3'd3;
   localparam logic [StatW-1:0] ST_EMPTY      = 3'd4;
   localparam logic [StatW-1:0] ST_NO_MATCH   = 3'd5;

   typedef struct packed {
      logic             valid;
      logic [EntW-1:0]  handle;
      logic [StatW-1:0] status;
      logic             last;
      logic [CntW-1:0]  live;
   } result_type;

   typedef struct packed {
      logic            rd_en;
      logic            wr_en;
      logic [EntW-1:0] addr;
      logic [SigW-1:0] wr_data;
   } sig_req_type;

   typedef struct packed {
      logic            push;
      logic            pop;
      logic [EntW-1:0] handle;
   } free_ctl_type;

   typedef struct packed {
      logic [CntW-1:0] top;
      logic [EntW-1:0] pop_handle;
      logic            is_free;
   } free_sts_type;

endpackage

[rtl/core/entity_signature_table.sv]
// Entity signature table. One command beat is taken at a time; req_tready
// stays low until its results are in the output register. Create runs EXEC
// and EMIT from a fresh handle and adds POP when reusing a freed one (stack
// read); destroy runs EXEC and EMIT; set and clear add RMW (read-modify-write
// through the single signature memory port). A view reads each handle below
// the high-water mark on that port and compares it (SCAN_RD, SCAN_EV), waiting
// on stalled output beats. Results leave through a one-beat output register;
// the sequencer waits only while that register still holds a beat that has
// not been taken. Reset clears the table at once (valid bits).
// Depends on est_pkg, est_ctrl, est_sig_store and est_free_stack.
module entity_signature_table
   import est_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // cmd[2:0], entity[8:3], component[13:9],
                                    // query_mask[45:14], zero[47:46]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // handle_out[5:0], status[8:6], live_count[15:9]
   output logic        rsp_tlast
);

   result_type        load;
   sig_req_type       sig_req;
   logic [SigW-1:0]   sig_rd;
   free_ctl_type      free_ctl;
   free_sts_type      free_sts;
   logic              slot_free;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   est_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (req_tdata[2:0]),
      .entity     (req_tdata[8:3]),
      .component  (req_tdata[13:9]),
      .query_mask (req_tdata[45:14]),
      .slot_free  (slot_free),
      .load       (load),
      .sig_req    (sig_req),
      .sig_rd     (sig_rd),
      .free_ctl   (free_ctl),
      .free_sts   (free_sts)
   );

   est_sig_store u_sig (
      .clock   (clock),
      .reset   (reset),
      .req     (sig_req),
      .rd_data (sig_rd)
   );

   est_free_stack u_free (
      .clock (clock),
      .reset (reset),
      .ctl   (free_ctl),
      .sts   (free_sts)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (load.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {load.live, load.status, load.handle};
         rsp_last_in  = load.last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   // never overwrite a beat that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load.valid |-> slot_free)
      else $error("output beat overwritten");

   // no input beat while a result is being produced
   a_no_accept_on_load: assert property (@(posedge clock) disable iff (reset)
      load.valid |-> !req_tready)
      else $error("input accepted while loading a result");

   // live count bounded by the table size
   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15:9] <= 7'(MAX_ENTITIES)))
      else $error("live count above table size");

   // free stack never exceeds the table
   a_top_bound: assert property (@(posedge clock) disable iff (reset)
      free_sts.top <= CntW'(MAX_ENTITIES))
      else $error("free stack overflow");
`endif

endmodule

[rtl/core/est_sig_store.sv]
// Signature memory: one component mask per handle, one port, registered read.
// Per-entry valid bits make never-written entries read as zero. Uses est_pkg.
module est_sig_store
   import est_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  sig_req_type       req,
   output logic [SigW-1:0]   rd_data
);

   logic [SigW-1:0]         mem_ff [MAX_ENTITIES];
   logic [MAX_ENTITIES-1:0] valid_ff;
   logic [MAX_ENTITIES-1:0] valid_in;
   logic [SigW-1:0]         rd_q_ff;
   logic                    hit_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req.wr_en) begin
         valid_in[req.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem_ff[req.addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_q_ff <= mem_ff[req.addr];
         hit_ff  <= valid_ff[req.addr];
      end
   end

   assign rd_data = hit_ff ? rd_q_ff : '0;

endmodule

[rtl/core/est_free_stack.sv]
// LIFO of freed handles with a per-handle free flag for quick membership checks.
// Stack memory has a registered read used on pop. Uses est_pkg.
module est_free_stack
   import est_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  free_ctl_type  ctl,
   output free_sts_type  sts
);

   logic [EntW-1:0]         mem_ff [MAX_ENTITIES];
   logic [CntW-1:0]         top_ff;
   logic [CntW-1:0]         top_in;
   logic [CntW-1:0]         top_m1;
   logic [MAX_ENTITIES-1:0] flag_ff;
   logic [MAX_ENTITIES-1:0] flag_in;
   logic [EntW-1:0]         rd_q_ff;
   logic                    clr_ff;

   assign top_m1 = top_ff - CntW'(1);

   always_comb begin
      top_in  = top_ff;
      flag_in = flag_ff;
      if (ctl.push) begin
         top_in              = top_ff + CntW'(1);
         flag_in[ctl.handle] = 1'b1;
      end
      if (ctl.pop) begin
         top_in = top_m1;
      end
      // popped handle is back in use once clr_ff, registered from the pop, clears its flag
      if (clr_ff) begin
         flag_in[rd_q_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff  <= '0;
         flag_ff <= '0;
         clr_ff  <= 1'b0;
      end else begin
         top_ff  <= top_in;
         flag_ff <= flag_in;
         clr_ff  <= ctl.pop;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem_ff[top_ff[EntW-1:0]] <= ctl.handle;
      end
      if (ctl.pop) begin
         rd_q_ff <= mem_ff[top_m1[EntW-1:0]];
      end
   end

   assign sts.top        = top_ff;
   assign sts.pop_handle = rd_q_ff;
   assign sts.is_free    = flag_ff[ctl.handle];

endmodule

[rtl/core/est_ctrl.sv]
// Command sequencer: decodes a beat, drives the signature port and free stack,
// runs the view scan with one-match lookahead for the last marker. Uses est_pkg.
module est_ctrl
   import est_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [CmdW-1:0]     cmd,
   input  logic [EntW-1:0]     entity,
   input  logic [CompW-1:0]    component,
   input  logic [QueryW-1:0]   query_mask,
   input  logic                slot_free,
   output result_type          load,
   output sig_req_type         sig_req,
   input  logic [SigW-1:0]     sig_rd,
   output free_ctl_type        free_ctl,
   input  free_sts_type        free_sts
);

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_EXEC    = 8'b0000_0010,
      S_POP     = 8'b0000_0100,
      S_RMW     = 8'b0000_1000,
      S_EMIT    = 8'b0001_0000,
      S_SCAN_RD = 8'b0010_0000,
      S_SCAN_EV = 8'b0100_0000,
      S_FLUSH   = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [CmdW-1:0]   cmd_ff, cmd_in;
   logic [EntW-1:0]   ent_ff, ent_in;
   logic [CompW-1:0]  comp_ff, comp_in;
   logic [QueryW-1:0] query_ff, query_in;
   logic [CntW-1:0]   hw_ff, hw_in;
   logic [EntW-1:0]   idx_ff, idx_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [EntW-1:0]   pend_idx_ff, pend_idx_in;
   logic [EntW-1:0]   res_handle_ff, res_handle_in;
   logic [StatW-1:0]  res_status_ff, res_status_in;

   logic              ent_bad;
   logic              match;
   logic              scan_end;
   logic [SigW-1:0]   comp_bit;

   assign req_tready = (state_ff == S_IDLE);
   assign ent_bad    = CntW'(ent_ff) >= hw_ff;
   assign match      = (QueryW'(sig_rd) & query_ff) == query_ff;
   assign scan_end   = (CntW'(idx_ff) + CntW'(1)) == hw_ff;
   assign comp_bit   = SigW'(1) << comp_ff;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      ent_in        = ent_ff;
      comp_in       = comp_ff;
      query_in      = query_ff;
      hw_in         = hw_ff;
      idx_in        = idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      res_handle_in = res_handle_ff;
      res_status_in = res_status_ff;

      load          = '0;
      load.live     = hw_ff - free_sts.top;
      sig_req       = '0;
      sig_req.addr  = ent_ff;
      free_ctl      = '0;
      free_ctl.handle = ent_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = cmd;
               ent_in   = entity;
               comp_in  = component;
               query_in = query_mask;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_handle_in = '0;
            res_status_in = ST_OK;
            state_in      = S_EMIT;
            unique case (cmd_ff) inside
               CMD_CREATE: begin
                  if (free_sts.top != '0) begin
                     free_ctl.pop = 1'b1;
                     state_in     = S_POP;
                  end else if (hw_ff < CntW'(MAX_ENTITIES)) begin
                     res_handle_in = hw_ff[EntW-1:0];
                     hw_in         = hw_ff + CntW'(1);
                  end else begin
                     res_status_in = ST_FULL;
                  end
               end
               CMD_DESTROY: begin
                  if (ent_bad || free_sts.is_free ||
                      free_sts.top >= CntW'(MAX_ENTITIES)) begin
                     res_status_in = ST_BAD_HANDLE;
                  end else begin
                     sig_req.wr_en = 1'b1;
                     free_ctl.push = 1'b1;
                  end
               end
               CMD_SET, CMD_CLEAR: begin
                  if (ent_bad) begin
                     res_status_in = ST_BAD_HANDLE;
                  end else if (int'(comp_ff) >= NUM_COMPONENTS) begin
                     res_status_in = ST_BAD_COMP;
                  end else begin
                     sig_req.rd_en = 1'b1;
                     state_in      = S_RMW;
                  end
               end
               CMD_VIEW: begin
                  if (query_ff == '0) begin
                     res_status_in = ST_EMPTY;
                  end else if (hw_ff == '0) begin
                     res_status_in = ST_NO_MATCH;
                  end else begin
                     idx_in        = '0;
                     pend_valid_in = 1'b0;
                     state_in      = S_SCAN_RD;
                  end
               end
               default: begin
                  // unused command: drop without a result
                  state_in = S_IDLE;
               end
            endcase
         end
         S_POP: begin
            res_handle_in = free_sts.pop_handle;
            state_in      = S_EMIT;
         end
         S_RMW: begin
            sig_req.wr_en   = 1'b1;
            sig_req.wr_data = (cmd_ff == CMD_SET) ? (sig_rd | comp_bit)
                                                  : (sig_rd & ~comp_bit);
            state_in        = S_EMIT;
         end
         S_EMIT: begin
            if (slot_free) begin
               load.valid  = 1'b1;
               load.handle = res_handle_ff;
               load.status = res_status_ff;
               load.last   = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_SCAN_RD: begin
            sig_req.rd_en = 1'b1;
            sig_req.addr  = idx_ff;
            state_in      = S_SCAN_EV;
         end
         S_SCAN_EV: begin
            // a new match releases the held one as a non-final beat
            if (!(match && pend_valid_ff) || slot_free) begin
               if (match) begin
                  if (pend_valid_ff) begin
                     load.valid  = 1'b1;
                     load.handle = pend_idx_ff;
                     load.status = ST_OK;
                  end
                  pend_valid_in = 1'b1;
                  pend_idx_in   = idx_ff;
               end
               if (scan_end) begin
                  state_in = S_FLUSH;
               end else begin
                  idx_in   = idx_ff + EntW'(1);
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_FLUSH: begin
            if (slot_free) begin
               load.valid  = 1'b1;
               load.last   = 1'b1;
               load.handle = pend_valid_ff ? pend_idx_ff : '0;
               load.status = pend_valid_ff ? ST_OK : ST_NO_MATCH;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         hw_ff         <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hw_ff         <= hw_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      ent_ff        <= ent_in;
      comp_ff       <= comp_in;
      query_ff      <= query_in;
      idx_ff        <= idx_in;
      pend_idx_ff   <= pend_idx_in;
      res_handle_ff <= res_handle_in;
      res_status_ff <= res_status_in;
   end

endmodule
